[hw/rtl/sip24_pkg.sv]
// Shared types, constants and the SipRound function for the SipHash-2-4 stream unit.
package sip24_pkg;

   localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
   localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
   localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
   localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
   localparam logic [63:0] SIP_FIN_XOR = 64'h00000000000000ff;
   localparam logic [3:0]  FULL_BYTES = 4'd8;
   localparam int          LEN_SHIFT = 56;

   localparam logic CSR_KEY_LOW  = 1'b0;
   localparam logic CSR_KEY_HIGH = 1'b1;

   typedef logic [3:0][63:0] sip_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_R1,
      ST_R2,
      ST_FIN,
      ST_HASH
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // take the input beat into the message registers
      logic rnd;        // apply one SipRound to the state
      logic pre_xor;    // xor the message word into v3 before the round
      logic post_xor;   // xor the message word into v0 after the round
      logic fin_xor;    // xor 0xff into v2 before the round
      logic pad_load;   // load the length-only block as the next word
      logic hash_load;  // capture the digest and close the message
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;       // the word in flight is the final one
      logic pad;        // a length-only block still has to follow
   } dp_status_type;

   function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
      rotl64 = (x << r) | (x >> (64 - r));
   endfunction

   function automatic sip_state_type sip_round(input sip_state_type v);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic [63:0] d;
      a = v[0];
      b = v[1];
      c = v[2];
      d = v[3];
      a = a + b; b = rotl64(b, 13); b = b ^ a; a = rotl64(a, 32);
      c = c + d; d = rotl64(d, 16); d = d ^ c;
      a = a + d; d = rotl64(d, 21); d = d ^ a;
      c = c + b; b = rotl64(b, 17); b = b ^ c; c = rotl64(c, 32);
      sip_round = {d, c, b, a};
   endfunction

endpackage

[hw/rtl/siphash_2_4_stream_unit.sv]
// Top level of the keyed SipHash-2-4 stream unit: ports, controller, datapath and checks.
// This unit hashes a message that arrives as 64-bit little-endian beats and returns one
// 64-bit SipHash-2-4 digest per message. Write the key with csr_index 0 (bytes 0 to 7)
// and 1 (bytes 8 to 15) while no message is open; the key is taken when a message's first
// beat starts its compression. Every beat with req_last low is taken as eight full bytes.
// The beat with req_last high carries 0 to 8 valid low bytes in req_nbytes (larger counts
// act as 8). The datapath performs one SipRound per cycle while it compresses or finalizes, and
// the next beat is taken during a non-final beat's second compression round, so the unit can
// take a new beat before it is through with the last one. A final beat with fewer than 8
// bytes takes 2 compression rounds, 4 finalization rounds and a load of the result
// register; a full final beat adds the compression of the length-only block. The
// digest sits in an output register, so a new message may start while rsp_stall holds
// the previous digest; only a second digest waits for the first one to leave.
module siphash_2_4_stream_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data,
   input  logic [3:0]  req_nbytes,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash
);

   sip24_pkg::dp_cmd_type    cmd;
   sip24_pkg::dp_status_type status;
   logic                     csr_write;

   // The key registers can take a write in any cycle.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   sip24_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sip24_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_data   (req_data),
      .req_nbytes (req_nbytes),
      .req_last   (req_last),
      .cmd        (cmd),
      .status     (status),
      .rsp_hash   (rsp_hash)
   );

   // A compression's first round is always followed by its second round.
   assert property (@(posedge clock) disable iff (reset)
      cmd.pre_xor |=> cmd.post_xor)
      else $error("first compression round not followed by second round");

   // Loading the digest never coincides with a round and always raises the result valid.
   assert property (@(posedge clock) disable iff (reset)
      cmd.hash_load |-> !cmd.rnd ##1 rsp_valid)
      else $error("digest load overlapped a round or did not raise rsp_valid");

   // A new beat is never taken while a length-only block is still pending.
   assert property (@(posedge clock) disable iff (reset)
      status.pad |-> !cmd.accept)
      else $error("input beat accepted while padding block pending");

endmodule

[hw/rtl/sip24_ctrl.sv]
// Controller state machine that sequences compression, finalization and the result beat.
module sip24_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  sip24_pkg::dp_status_type status,
   output sip24_pkg::dp_cmd_type    cmd
);

   sip24_pkg::ctrl_state_type state_ff, state_in;
   logic [1:0] fin_cnt_ff, fin_cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sip24_pkg::ST_IDLE;
         fin_cnt_ff   <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fin_cnt_ff   <= fin_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      fin_cnt_in = fin_cnt_ff;
      cmd        = '0;
      ready      = 1'b0;
      case (state_ff)
         sip24_pkg::ST_IDLE: begin
            ready = 1'b1;
            if (req_valid) begin
               state_in = sip24_pkg::ST_R1;
            end
         end
         sip24_pkg::ST_R1: begin
            cmd.rnd     = 1'b1;
            cmd.pre_xor = 1'b1;
            state_in    = sip24_pkg::ST_R2;
         end
         sip24_pkg::ST_R2: begin
            cmd.rnd      = 1'b1;
            cmd.post_xor = 1'b1;
            if (status.pad) begin
               cmd.pad_load = 1'b1;
               state_in     = sip24_pkg::ST_R1;
            end else if (status.last) begin
               fin_cnt_in = 2'd0;
               state_in   = sip24_pkg::ST_FIN;
            end else begin
               // The next word may enter while this one finishes.
               ready    = 1'b1;
               state_in = req_valid ? sip24_pkg::ST_R1 : sip24_pkg::ST_IDLE;
            end
         end
         sip24_pkg::ST_FIN: begin
            cmd.rnd     = 1'b1;
            cmd.fin_xor = (fin_cnt_ff == 2'd0);
            fin_cnt_in  = fin_cnt_ff + 2'd1;
            if (fin_cnt_ff == 2'd3) begin
               state_in = sip24_pkg::ST_HASH;
            end
         end
         sip24_pkg::ST_HASH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.hash_load = 1'b1;
               state_in      = sip24_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sip24_pkg::ST_IDLE;
         end
      endcase
      cmd.accept = ready && req_valid;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.hash_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign req_stall = !ready;
   assign rsp_valid = rsp_valid_ff;

endmodule

[hw/rtl/sip24_dp.sv]
// Datapath: key registers, message word, SipHash state, length count and result register.
module sip24_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic                     csr_index,
   input  logic [63:0]              csr_data,
   input  logic [63:0]              req_data,
   input  logic [3:0]               req_nbytes,
   input  logic                     req_last,
   input  sip24_pkg::dp_cmd_type     cmd,
   output sip24_pkg::dp_status_type  status,
   output logic [63:0]              rsp_hash
);

   logic [63:0]             key_low_ff, key_low_in;
   logic [63:0]             key_high_ff, key_high_in;
   sip24_pkg::sip_state_type v_ff, v_in;
   logic [63:0]             m_ff, m_in;
   logic [7:0]              len_ff, len_in;
   logic                    in_msg_ff, in_msg_in;
   logic                    first_ff, first_in;
   logic                    last_ff, last_in;
   logic                    pad_ff, pad_in;
   logic [63:0]             hash_ff, hash_in;

   logic [3:0]              n_sat;
   logic                    full_word;
   logic [63:0]             byte_mask;
   logic [7:0]              len_base;
   logic [7:0]              len_next;
   sip24_pkg::sip_state_type v_init;
   sip24_pkg::sip_state_type v_src;
   sip24_pkg::sip_state_type v_rnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         len_ff      <= '0;
         in_msg_ff   <= 1'b0;
         first_ff    <= 1'b0;
         last_ff     <= 1'b0;
         pad_ff      <= 1'b0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         len_ff      <= len_in;
         in_msg_ff   <= in_msg_in;
         first_ff    <= first_in;
         last_ff     <= last_in;
         pad_ff      <= pad_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      m_ff    <= m_in;
      hash_ff <= hash_in;
   end

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_write) begin
         case (csr_index)
            sip24_pkg::CSR_KEY_LOW:  key_low_in  = csr_data;
            sip24_pkg::CSR_KEY_HIGH: key_high_in = csr_data;
            default: ;
         endcase
      end
   end

   // Input word: saturate the byte count, mask unused bytes and fold in the length.
   always_comb begin
      n_sat     = (req_nbytes > sip24_pkg::FULL_BYTES) ? sip24_pkg::FULL_BYTES : req_nbytes;
      full_word = !req_last || (n_sat == sip24_pkg::FULL_BYTES);
      for (int i = 0; i < 8; i++) begin
         byte_mask[8*i +: 8] = (4'(i) < n_sat) ? 8'hff : 8'h00;
      end
      len_base = in_msg_ff ? len_ff : 8'd0;
      len_next = full_word ? (len_base + 8'd8) : (len_base + {4'd0, n_sat});
   end

   always_comb begin
      m_in      = m_ff;
      len_in    = len_ff;
      in_msg_in = in_msg_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      pad_in    = pad_ff;
      if (cmd.accept) begin
         len_in    = len_next;
         in_msg_in = 1'b1;
         first_in  = !in_msg_ff;
         last_in   = req_last;
         pad_in    = req_last && full_word;
         if (full_word) begin
            m_in = req_data;
         end else begin
            m_in = (req_data & byte_mask) | ({56'd0, len_next} << sip24_pkg::LEN_SHIFT);
         end
      end else if (cmd.pad_load) begin
         m_in   = {56'd0, len_ff} << sip24_pkg::LEN_SHIFT;
         pad_in = 1'b0;
      end
      if (cmd.rnd) begin
         first_in = 1'b0;
      end
      if (cmd.hash_load) begin
         in_msg_in = 1'b0;
      end
   end

   // One SipRound per cycle while cmd.rnd is set; the first round of a message starts from the key.
   always_comb begin
      v_init[0] = key_low_ff ^ sip24_pkg::SIP_C0;
      v_init[1] = key_high_ff ^ sip24_pkg::SIP_C1;
      v_init[2] = key_low_ff ^ sip24_pkg::SIP_C2;
      v_init[3] = key_high_ff ^ sip24_pkg::SIP_C3;
      v_src = first_ff ? v_init : v_ff;
      if (cmd.pre_xor) begin
         v_src[3] = v_src[3] ^ m_ff;
      end
      if (cmd.fin_xor) begin
         v_src[2] = v_src[2] ^ sip24_pkg::SIP_FIN_XOR;
      end
      v_rnd = sip24_pkg::sip_round(v_src);
      if (cmd.post_xor) begin
         v_rnd[0] = v_rnd[0] ^ m_ff;
      end
      v_in = cmd.rnd ? v_rnd : v_ff;
   end

   assign hash_in = cmd.hash_load ? (v_ff[0] ^ v_ff[1] ^ v_ff[2] ^ v_ff[3]) : hash_ff;

   assign status.last = last_ff;
   assign status.pad  = pad_ff;
   assign rsp_hash    = hash_ff;

endmodule
